FILE: design/tccs_pkg.sv
package tccs_pkg;

  localparam int TEXT_COLS   = 40;
  localparam int TEXT_ROWS   = 30;
  localparam int CHAR_W      = 8;
  localparam int CHAR_H      = 8;
  localparam int DISP_WIDTH  = 320;
  localparam int DISP_HEIGHT = 240;

  localparam int COORD_W    = 9;
  localparam int CELL_W     = 6;
  localparam int BAND_W     = 4;
  localparam int CODE_W     = 8;
  localparam int AREA_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [BAND_W-1:0]  band_t;
  typedef logic [AREA_W-1:0]  area_t;
  typedef logic [CODE_W-1:0]  code_t;

  localparam cell_t  COL_MAX = CELL_W'(TEXT_COLS - 1);
  localparam cell_t  ROW_MAX = CELL_W'(TEXT_ROWS - 1);
  localparam coord_t X_SPAN  = COORD_W'(DISP_WIDTH - 1);

  localparam code_t CH_BS    = 8'h08;
  localparam code_t CH_LF    = 8'h0a;
  localparam code_t CH_FF    = 8'h0c;
  localparam code_t CH_CR    = 8'h0d;
  localparam code_t CH_SPACE = 8'h20;

  localparam band_t  RST_HEADER   = 4'd1;
  localparam band_t  RST_FOOTER   = 4'd1;
  localparam coord_t RST_X_ORIGIN = '0;
  localparam coord_t RST_Y_ORIGIN = '0;
  localparam coord_t RST_SCROLL   =
    COORD_W'(int'(RST_Y_ORIGIN) + int'(RST_HEADER) * CHAR_H);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_ROWS = 2'd0,
    REG_FOOTER_ROWS = 2'd1,
    REG_X_ORIGIN    = 2'd2,
    REG_Y_ORIGIN    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_GLYPH  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_PLACE,
    OP_PRINT,
    OP_BS,
    OP_LF,
    OP_FF,
    OP_CR
  } op_t;

  typedef struct packed {
    op_t   op;
    code_t glyph;
    cell_t col;
    cell_t row;
  } cmd_t;

  typedef struct packed {
    band_t  header;
    band_t  footer;
    coord_t x_origin;
    coord_t y_origin;
    area_t  area_top;
    area_t  area_size;
    area_t  area_end;
  } cfg_t;

endpackage

FILE: design/tccs_cfg.sv
module tccs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tccs_pkg::cfg_t                   cfg
);
  import tccs_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  band_t  hdr, ftr;
  coord_t xo, yo;

  // scroll ring geometry follows the bands; small rings are held at one text line
  function automatic cfg_t derive(input band_t h, input band_t f,
                                  input coord_t x, input coord_t y);
    cfg_t  c;
    area_t band;
    c.header    = h;
    c.footer    = f;
    c.x_origin  = x;
    c.y_origin  = y;
    band        = (AREA_W'(h) + AREA_W'(f)) * AREA_W'(CHAR_H);
    c.area_top  = AREA_W'(y) + AREA_W'(h) * AREA_W'(CHAR_H);
    c.area_size = (band > AREA_W'(DISP_HEIGHT - CHAR_H)) ? AREA_W'(CHAR_H)
                                                         : AREA_W'(DISP_HEIGHT) - band;
    c.area_end  = c.area_top + c.area_size;
    return c;
  endfunction

  always_comb begin
    hdr = cfg_r.header;
    ftr = cfg_r.footer;
    xo  = cfg_r.x_origin;
    yo  = cfg_r.y_origin;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_ROWS: hdr = cfg_wdata[BAND_W-1:0];
        REG_FOOTER_ROWS: ftr = cfg_wdata[BAND_W-1:0];
        REG_X_ORIGIN:    xo  = cfg_wdata[COORD_W-1:0];
        REG_Y_ORIGIN:    yo  = cfg_wdata[COORD_W-1:0];
        default: begin
        end
      endcase
    end
    cfg_nxt = derive(hdr, ftr, xo, yo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= derive(RST_HEADER, RST_FOOTER, RST_X_ORIGIN, RST_Y_ORIGIN);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/tccs_front.sv
module tccs_front (
  input  logic                       in_valid,
  input  logic                       in_func,
  input  logic [tccs_pkg::CODE_W-1:0] in_char_code,
  input  logic [tccs_pkg::CELL_W-1:0] in_col,
  input  logic [tccs_pkg::CELL_W-1:0] in_row,
  output logic                       in_stall,
  input  logic                       q_full,
  output logic                       q_push,
  output tccs_pkg::cmd_t             q_cmd
);
  import tccs_pkg::*;

  logic keep;

  always_comb begin
    q_cmd.glyph = in_char_code;
    q_cmd.col   = (in_col > COL_MAX) ? COL_MAX : in_col;
    q_cmd.row   = (in_row > ROW_MAX) ? ROW_MAX : in_row;
    q_cmd.op    = OP_PRINT;
    keep        = 1'b1;
    if (in_func) begin
      q_cmd.op = OP_PLACE;
    end else if (in_char_code < CH_SPACE) begin
      unique case (in_char_code)
        CH_BS:   q_cmd.op = OP_BS;
        CH_LF:   q_cmd.op = OP_LF;
        CH_FF:   q_cmd.op = OP_FF;
        CH_CR:   q_cmd.op = OP_CR;
        default: keep = 1'b0;   // unsupported control, dropped here
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

FILE: design/tccs_queue.sv
module tccs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tccs_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           head_valid,
  output logic           full,
  output tccs_pkg::cmd_t head
);
  import tccs_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] adv(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? adv(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? adv(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head       = slot_r[rd_ptr_r];

endmodule

FILE: design/tccs_back.sv
module tccs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tccs_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  input  tccs_pkg::cmd_t               q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_kind,
  output logic [tccs_pkg::COORD_W-1:0] out_x_start,
  output logic [tccs_pkg::COORD_W-1:0] out_x_end,
  output logic [tccs_pkg::COORD_W-1:0] out_y_start,
  output logic [tccs_pkg::COORD_W-1:0] out_y_end,
  output logic [tccs_pkg::CODE_W-1:0]  out_glyph,
  output logic [tccs_pkg::COORD_W-1:0] out_scroll_line,
  output logic                         out_last
);
  import tccs_pkg::*;

  typedef enum logic [1:0] {
    PH_MAIN,
    PH_SCROLL,
    PH_CLEAR
  } phase_t;

  typedef struct packed {
    kind_t  kind;
    coord_t xs;
    coord_t xe;
    coord_t ys;
    coord_t ye;
    code_t  glyph;
    coord_t scroll_line;
    logic   last;
  } res_t;

  phase_t phase_r, phase_nxt;
  cell_t  col_r, col_nxt;
  cell_t  row_r, row_nxt;
  coord_t ss_r, ss_nxt;
  logic   out_valid_r;
  res_t   out_r;
  res_t   res;
  logic   emit;
  logic   out_free;

  cell_t         row_sel, col_sel, home_row;
  logic          in_band, lf_scroll;
  logic [CELL_W:0] row_inc;
  area_t         ys_scr, ys_wrap, ys_fix, ss_inc;
  coord_t        gx, gy, ss_adv, clr_y;

  function automatic res_t mk_win(input kind_t k, input coord_t x, input coord_t y,
                                  input coord_t w, input coord_t h, input code_t g,
                                  input logic lst);
    res_t r;
    r.kind        = k;
    r.xs          = x;
    r.xe          = x + w;
    r.ys          = y;
    r.ye          = y + h;
    r.glyph       = g;
    r.scroll_line = '0;
    r.last        = lst;
    return r;
  endfunction

  function automatic res_t mk_scroll(input coord_t sl);
    res_t r;
    r             = '0;
    r.kind        = KIND_SCROLL;
    r.scroll_line = sl;
    return r;
  endfunction

  always_comb begin
    out_free = !out_valid_r || !out_stall;

    // glyph cell position: fixed bands map straight, ring rows offset by scroll start
    row_sel = (q_head.op == OP_PLACE) ? q_head.row : row_r;
    col_sel = (q_head.op == OP_PLACE) ? q_head.col : col_r;
    in_band = (row_sel < CELL_W'(cfg.header)) ||
              ((CELL_W+1)'(row_sel) + (CELL_W+1)'(cfg.footer) > (CELL_W+1)'(TEXT_ROWS - 1));
    ys_scr  = AREA_W'(ss_r) + AREA_W'(row_sel - CELL_W'(cfg.header)) * AREA_W'(CHAR_H);
    ys_wrap = (ys_scr >= cfg.area_end) ? ys_scr - cfg.area_size : ys_scr;
    ys_fix  = AREA_W'(cfg.y_origin) + AREA_W'(row_sel) * AREA_W'(CHAR_H);
    gy      = in_band ? ys_fix[COORD_W-1:0] : ys_wrap[COORD_W-1:0];
    gx      = cfg.x_origin + COORD_W'(col_sel) * COORD_W'(CHAR_W);

    // one text line of scroll, then the line that became exposed
    ss_inc  = AREA_W'(ss_r) + AREA_W'(CHAR_H);
    ss_adv  = (ss_inc >= cfg.area_end) ? cfg.area_top[COORD_W-1:0] : ss_inc[COORD_W-1:0];
    clr_y   = (AREA_W'(ss_r) < cfg.area_top + AREA_W'(CHAR_H))
            ? COORD_W'(cfg.area_end - AREA_W'(CHAR_H))
            : ss_r - COORD_W'(CHAR_H);

    row_inc   = (CELL_W+1)'(row_r) + 1'b1;
    lf_scroll = (row_inc + (CELL_W+1)'(cfg.footer)) > (CELL_W+1)'(TEXT_ROWS - 1);
    home_row  = (CELL_W'(cfg.header) > ROW_MAX) ? ROW_MAX : CELL_W'(cfg.header);

    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ss_nxt    = ss_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    res       = mk_win(KIND_GLYPH, gx, gy, COORD_W'(CHAR_W - 1), COORD_W'(CHAR_H - 1),
                       q_head.glyph, 1'b1);

    unique case (phase_r)
      PH_MAIN: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_PLACE: begin
              emit    = 1'b1;
              col_nxt = q_head.col;
              row_nxt = q_head.row;
            end
            OP_PRINT: begin
              emit = 1'b1;
              if (col_r == COL_MAX) begin
                col_nxt = '0;
                if (lf_scroll) begin
                  res.last  = 1'b0;
                  phase_nxt = PH_SCROLL;
                end else begin
                  row_nxt = row_inc[CELL_W-1:0];
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            OP_LF: begin
              col_nxt = '0;
              if (lf_scroll) begin
                emit      = 1'b1;
                res       = mk_scroll(ss_adv);
                ss_nxt    = ss_adv;
                phase_nxt = PH_CLEAR;
              end else begin
                row_nxt = row_inc[CELL_W-1:0];
              end
            end
            OP_FF: begin
              emit    = 1'b1;
              res     = mk_win(KIND_CLEAR, cfg.x_origin, cfg.area_top[COORD_W-1:0], X_SPAN,
                               COORD_W'(cfg.area_size - 1'b1), '0, 1'b1);
              col_nxt = '0;
              row_nxt = home_row;
              ss_nxt  = cfg.area_top[COORD_W-1:0];
            end
            OP_BS: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end
            end
            OP_CR: begin
              col_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      PH_SCROLL: begin
        if (out_free) begin
          emit      = 1'b1;
          res       = mk_scroll(ss_adv);
          ss_nxt    = ss_adv;
          phase_nxt = PH_CLEAR;
        end
      end
      PH_CLEAR: begin
        if (out_free) begin
          emit      = 1'b1;
          res       = mk_win(KIND_CLEAR, cfg.x_origin, clr_y, X_SPAN,
                             COORD_W'(CHAR_H - 1), '0, 1'b1);
          phase_nxt = PH_MAIN;
        end
      end
      default: begin
        phase_nxt = PH_MAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAIN;
      col_r       <= '0;
      row_r       <= '0;
      ss_r        <= RST_SCROLL;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ss_r    <= ss_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_r.kind;
  assign out_x_start     = out_r.xs;
  assign out_x_end       = out_r.xe;
  assign out_y_start     = out_r.ys;
  assign out_y_end       = out_r.ye;
  assign out_glyph       = out_r.glyph;
  assign out_scroll_line = out_r.scroll_line;
  assign out_last        = out_r.last;

`ifndef ASSERT_OFF
  a_tail_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_MAIN) |-> out_valid_r)
    else $error("scroll tail pending without a result in the output register");

  a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_SCROLL) |-> !out_r.last)
    else $error("scroll command flagged as last");

  a_clear_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CLEAR && out_free) |=>
      (out_valid_r && out_r.last && out_r.kind == KIND_CLEAR))
    else $error("scroll sequence did not end with a final clear");

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= COL_MAX) && (row_r <= ROW_MAX))
    else $error("cursor left the text grid");
`endif

endmodule

FILE: design/text_console_cursor_scroll_unit.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   func, char_code, col, row
// out      output     out_valid / out_stall kind, x/y window, glyph, scroll_line, last
// cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One result per cycle from the result register while out_stall is low; cursor-only
// controls emit none. out_valid rises once an accepted request has left the queue and
// its result is registered; the sequencer pops no request while a scroll or clear is due.
// A two-entry command queue sits between front and back; in_stall is high while it is full.
// out_stall holds a valid result in the result register and halts the back end.
// rst_n is synchronous, active low: cursor, scroll start, registers and queue are reset.
module text_console_cursor_scroll_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [tccs_pkg::CODE_W-1:0]      in_char_code,
  input  logic [tccs_pkg::CELL_W-1:0]      in_col,
  input  logic [tccs_pkg::CELL_W-1:0]      in_row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic [tccs_pkg::COORD_W-1:0]     out_x_start,
  output logic [tccs_pkg::COORD_W-1:0]     out_x_end,
  output logic [tccs_pkg::COORD_W-1:0]     out_y_start,
  output logic [tccs_pkg::COORD_W-1:0]     out_y_end,
  output logic [tccs_pkg::CODE_W-1:0]      out_glyph,
  output logic [tccs_pkg::COORD_W-1:0]     out_scroll_line,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tccs_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head;
  logic push, pop, q_full, q_valid;

  tccs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tccs_front u_front (
    .in_valid     (in_valid),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (push),
    .q_cmd        (push_cmd)
  );

  tccs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (q_valid),
    .full       (q_full),
    .head       (head)
  );

  tccs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_head          (head),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_x_start     (out_x_start),
    .out_x_end       (out_x_end),
    .out_y_start     (out_y_start),
    .out_y_end       (out_y_end),
    .out_glyph       (out_glyph),
    .out_scroll_line (out_scroll_line),
    .out_last        (out_last)
  );

endmodule
